@@ design/b64u_pkg.sv @@
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types and character tables for the base64url stream codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64u_pkg;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } result_t;

  // one queue entry: the results of one accepted item
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } dec_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2D;
    end else begin
      c = 8'h5F;
    end
    return c;
  endfunction

  function automatic dec_t dec_char(input logic [7:0] c);
    dec_t d;
    d.ok    = 1'b1;
    d.value = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      d.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      d.value = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      d.value = 6'(c - 8'h30 + 8'd52);
    end else if (c inside {8'h2D, 8'h2B}) begin
      d.value = 6'd62;
    end else if (c inside {8'h5F, 8'h2F}) begin
      d.value = 6'd63;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ design/b64u_front.sv @@
// ----------------------------------------------------------------------------
// b64u_front
// Accepts items, keeps the bit accumulator and builds the results of each
// item as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic             cfg_data,
  input  wire logic             accept,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  output logic                  enq,
  output b64u_pkg::entry_t      entry
);

  logic        mode;
  logic [11:0] acc;
  logic [3:0]  bc;
  logic        stopped;

  logic [11:0] acc_next;
  logic [3:0]  bc_next;
  logic        stopped_next;
  logic        has_res;

  logic [11:0] acc_e;
  logic [3:0]  bc_e;
  logic [11:0] acc_d;
  logic [3:0]  bc_d;
  b64u_pkg::dec_t dv;
  logic [5:0]  c0;
  logic [5:0]  c1;
  logic        two;
  logic [7:0]  dbyte;

  always_comb begin
    acc_e = {acc[3:0], in_byte};
    bc_e  = bc + 4'd8;
    dv    = b64u_pkg::dec_char(in_byte);
    acc_d = {acc[5:0], dv.value};
    bc_d  = bc + 4'd6;

    acc_next     = acc;
    bc_next      = bc;
    stopped_next = stopped;
    has_res      = 1'b0;
    c0           = 6'd0;
    c1           = 6'd0;
    two          = 1'b0;
    dbyte        = 8'd0;
    entry        = '0;

    if (!mode) begin
      has_res  = 1'b1;
      acc_next = acc_e;
      case (bc_e)
        4'd8: begin
          c0      = acc_e[7:2];
          c1      = {acc_e[1:0], 4'b0000};
          bc_next = 4'd2;
        end
        4'd10: begin
          c0      = acc_e[9:4];
          c1      = {acc_e[3:0], 2'b00};
          bc_next = 4'd4;
        end
        4'd12: begin
          c0      = acc_e[11:6];
          c1      = acc_e[5:0];
          two     = 1'b1;
          bc_next = 4'd0;
        end
        default: begin
          c0      = acc_e[7:2];
          c1      = {acc_e[1:0], 4'b0000};
          bc_next = 4'd2;
        end
      endcase
      two            = two | in_last;
      entry.two      = two;
      entry.r0.data  = b64u_pkg::enc_char(c0);
      entry.r0.valid = 1'b1;
      entry.r0.last  = in_last && !two;
      entry.r1.data  = b64u_pkg::enc_char(c1);
      entry.r1.valid = 1'b1;
      entry.r1.last  = in_last;
    end else begin
      if (!stopped) begin
        if (in_byte == b64u_pkg::CHAR_PAD) begin
          stopped_next = 1'b1;
        end else if (dv.ok) begin
          acc_next = acc_d;
          bc_next  = bc_d;
          case (bc_d)
            4'd8: begin
              dbyte   = acc_d[7:0];
              has_res = 1'b1;
              bc_next = 4'd0;
            end
            4'd10: begin
              dbyte   = acc_d[9:2];
              has_res = 1'b1;
              bc_next = 4'd2;
            end
            4'd12: begin
              dbyte   = acc_d[11:4];
              has_res = 1'b1;
              bc_next = 4'd4;
            end
            default: begin
              dbyte   = 8'd0;
            end
          endcase
        end
      end
      entry.r0.data  = dbyte;
      entry.r0.valid = has_res;
      entry.r0.last  = in_last;
      has_res        = has_res | in_last;
    end

    if (in_last) begin
      acc_next     = 12'd0;
      bc_next      = 4'd0;
      stopped_next = 1'b0;
    end
  end

  assign enq = accept && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= 1'b0;
      acc     <= 12'd0;
      bc      <= 4'd0;
      stopped <= 1'b0;
    end else if (cfg_write) begin
      mode    <= cfg_data;
      acc     <= 12'd0;
      bc      <= 4'd0;
      stopped <= 1'b0;
    end else if (accept) begin
      acc     <= acc_next;
      bc      <= bc_next;
      stopped <= stopped_next;
    end
  end

endmodule

`default_nettype wire

@@ design/b64u_fifo.sv @@
// ----------------------------------------------------------------------------
// b64u_fifo
// Two-entry queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire b64u_pkg::entry_t wr_entry,
  input  wire logic             rd,
  output b64u_pkg::entry_t      rd_entry,
  output logic                  full,
  output logic                  empty
);

  b64u_pkg::entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

`default_nettype wire

@@ design/b64u_back.sv @@
// ----------------------------------------------------------------------------
// b64u_back
// Unpacks queue entries into single results and holds the oldest result in
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire b64u_pkg::entry_t q_entry,
  output logic                  q_rd,
  input  wire logic             pop,
  output logic                  empty,
  output logic [7:0]            out_byte,
  output logic                  out_valid,
  output logic                  out_last
);

  logic             full_reg;
  logic             sel;
  logic             load;
  b64u_pkg::result_t res;

  assign load  = !q_empty && (!full_reg || pop);
  assign q_rd  = load && (sel || !q_entry.two);
  assign res   = sel ? q_entry.r1 : q_entry.r0;
  assign empty = !full_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_reg <= 1'b0;
      sel      <= 1'b0;
    end else begin
      if (load) begin
        full_reg <= 1'b1;
        sel      <= !sel && q_entry.two;
      end else if (pop) begin
        full_reg <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= res.data;
      out_valid <= res.valid;
      out_last  <= res.last;
    end
  end

endmodule

`default_nettype wire

@@ design/base64url_stream_codec.sv @@
// ----------------------------------------------------------------------------
// base64url_stream_codec
// Streaming unpadded base64url encoder / decoder, one byte per item.
//
// Input queue side: drive in_byte/in_last with push; the item is taken at an
// edge with push high and full low. in_last ends a message and clears state.
// Result queue side: while empty is low the oldest result is on out_byte,
// out_valid and out_last; pop takes it. Results stay put while pop is low.
// cfg_write/cfg_data set the mode (0 encode, 1 decode) and clear the
// accumulator; write only while no item is in flight.
// The results of an item pass through the queue and then the output register;
// a second character of the same item follows the first.
// Throughput: while pop is high or the output register is empty it moves one
// result per cycle, so decode runs at one item per cycle and encode more
// slowly, as each byte gives one or two characters. A two-entry queue sits
// between the item front end and the result back end, so input is taken
// while the receiver stalls until that queue fills; then full rises.
// Reset empties the queue and output register and selects encode mode.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_stream_codec (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_last
);

  logic             accept;
  logic             enq;
  b64u_pkg::entry_t entry;
  b64u_pkg::entry_t q_entry;
  logic             q_rd;
  logic             q_empty;

  assign accept = push && !full;

  b64u_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .enq       (enq),
    .entry     (entry)
  );

  b64u_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (enq),
    .wr_entry (entry),
    .rd       (q_rd),
    .rd_entry (q_entry),
    .full     (full),
    .empty    (q_empty)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (q_entry),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

@@ design/b64u_checker.sv @@
// ----------------------------------------------------------------------------
// b64u_checker
// Port-level checks for the base64url stream codec, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_valid,
  input wire logic       out_last
);

  a_reset_empty : assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_reset_not_full : assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_marker_form : assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_valid) |-> (out_last && out_byte == 8'd0))
    else $error("end-only marker malformed");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_valid)
                          && $stable(out_last)))
    else $error("stalled item changed");

endmodule

bind base64url_stream_codec b64u_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_byte  (out_byte),
  .out_valid (out_valid),
  .out_last  (out_last)
);

`default_nettype wire

@@ tb/base64url_stream_codec_tb.sv @@
// ----------------------------------------------------------------------------
// base64url_stream_codec_tb
// Self-checking bench for the streaming base64url codec. Items go in through
// the push/full side and are run through an in-bench bit accumulator model;
// every popped result is checked against the oldest predicted one. Directed
// edge cases in both modes come first, then random messages in phases with
// mode writes between them; the first random run adds idle bursts on both sides.
// ----------------------------------------------------------------------------
module base64url_stream_codec_tb;

  localparam int   LIMIT_CYCLES = 500000;
  localparam logic MODE_ENCODE  = 1'b0;
  localparam logic MODE_DECODE  = 1'b1;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data  = 1'b0;
  logic       push      = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  // codec model state
  logic       codec_mode;
  logic [11:0] acc_bits;
  int         acc_cnt;
  logic       pad_seen;

  b64u_pkg::result_t transcoded_q[$];
  b64u_pkg::result_t got_r;
  b64u_pkg::result_t want_r;
  int         errors      = 0;
  int         items_sent  = 0;
  int         cycle_count = 0;
  int         rx_hold     = 0;
  logic       tx_bursts   = 1'b1;
  logic       rx_bursts   = 1'b1;

  base64url_stream_codec u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic std);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = "A" + {2'b00, v};
    end else if (v < 6'd52) begin
      c = "a" + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = "0" + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = std ? "+" : "-";
    end else begin
      c = std ? "/" : "_";
    end
    return c;
  endfunction

  function automatic logic sextet_value(input logic [7:0] c, output logic [5:0] v);
    logic ok;
    ok = 1'b1;
    v  = 6'd0;
    if (c >= "A" && c <= "Z") begin
      v = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      v = 6'(c - "a" + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      v = 6'(c - "0" + 8'd52);
    end else if (c == "-" || c == "+") begin
      v = 6'd62;
    end else if (c == "_" || c == "/") begin
      v = 6'd63;
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void clear_codec_state();
    acc_bits = '0;
    acc_cnt  = 0;
    pad_seen = 1'b0;
  endfunction

  function automatic void b64_transcode(input logic [7:0] b, input logic l);
    b64u_pkg::result_t outs [2];
    int         n;
    logic [5:0] v;
    n = 0;
    if (codec_mode == MODE_ENCODE) begin
      acc_bits = {acc_bits[3:0], b};
      acc_cnt += 8;
      while (acc_cnt >= 6 && n < 2) begin
        v = 6'(acc_bits >> (acc_cnt - 6));
        acc_cnt -= 6;
        outs[n] = '{sextet_char(v, 1'b0), 1'b1, 1'b0};
        n++;
      end
      if (l) begin
        // leftover bits, zero-filled on the right
        if (acc_cnt > 0 && acc_cnt < 6 && n < 2) begin
          v = 6'(acc_bits << (6 - acc_cnt));
          outs[n] = '{sextet_char(v, 1'b0), 1'b1, 1'b0};
          n++;
        end
        outs[n-1].last = 1'b1;
        clear_codec_state();
      end
    end else begin
      if (!pad_seen) begin
        if (b == b64u_pkg::CHAR_PAD) begin
          pad_seen = 1'b1;
        end else if (sextet_value(b, v)) begin
          acc_bits = {acc_bits[5:0], v};
          acc_cnt += 6;
          if (acc_cnt >= 8) begin
            outs[n] = '{8'(acc_bits >> (acc_cnt - 8)), 1'b1, 1'b0};
            acc_cnt -= 8;
            n++;
          end
        end
      end
      if (l) begin
        if (n > 0) begin
          outs[0].last = 1'b1;
        end else begin
          outs[0] = '{8'h00, 1'b0, 1'b1};
          n = 1;
        end
        clear_codec_state();
      end
    end
    for (int i = 0; i < n; i++) begin
      transcoded_q = {transcoded_q, outs[i]};
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    if (tx_bursts && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (full);
    b64_transcode(b, l);
    items_sent++;
  endtask

  task automatic drain_outputs();
    push <= 1'b0;
    @(posedge clk);
    while (transcoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain_outputs();
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    codec_mode = m;
    clear_codec_state();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_encode_msg(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_item(b, i == len - 1);
    end
  endtask

  // mostly well-formed text with some noise (all noise when noisy), optional '=' tail with optional junk after it
  task automatic send_decode_msg(input int len, input logic noisy);
    logic       padded;
    int         n_pad;
    int         n_junk;
    logic [7:0] c;
    padded = !noisy && ($urandom_range(0, 3) == 0);
    n_pad  = padded ? $urandom_range(1, 2) : 0;
    n_junk = padded ? $urandom_range(0, 2) : 0;
    for (int i = 0; i < len; i++) begin
      if (noisy || $urandom_range(0, 99) < 10) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        c = sextet_char(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
      end
      send_item(c, !padded && i == len - 1);
    end
    for (int i = 0; i < n_pad; i++) begin
      send_item(b64u_pkg::CHAR_PAD, n_junk == 0 && i == n_pad - 1);
    end
    for (int i = 0; i < n_junk; i++) begin
      send_item(8'($urandom_range(0, 255)), i == n_junk - 1);
    end
  endtask

  task automatic test_encode_edges();
    set_mode(MODE_ENCODE);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    // 62 and 63 give '-' and '_'
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b1);
  endtask

  task automatic test_decode_edges();
    set_mode(MODE_DECODE);
    send_text("Az-_");
    send_text("Za0+/9");
    // skipped characters, padding, data after padding, end-only marker
    send_item("Q", 1'b0);
    send_item(8'h00, 1'b0);
    send_item("Q", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(b64u_pkg::CHAR_PAD, 1'b0);
    send_item("A", 1'b1);
  endtask

  task automatic test_mode_write_clears();
    set_mode(MODE_ENCODE);
    send_item(8'h12, 1'b0);
    set_mode(MODE_ENCODE);
    send_item(8'h34, 1'b1);
    set_mode(MODE_DECODE);
    send_item("Q", 1'b0);
    set_mode(MODE_DECODE);
    send_text("QQ");
  endtask

  task automatic test_random(input int n_items, input logic with_bursts);
    int   stop_at;
    int   phase_end;
    int   len;
    logic m;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      m = 1'($urandom_range(0, 1));
      set_mode(m);
      tx_bursts = with_bursts && ($urandom_range(0, 3) != 0);
      rx_bursts = with_bursts && ($urandom_range(0, 3) != 0);
      phase_end = items_sent + $urandom_range(60, 200);
      if (phase_end > stop_at) phase_end = stop_at;
      while (items_sent < phase_end) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (m == MODE_ENCODE) begin
          send_encode_msg(len);
        end else begin
          send_decode_msg(len, $urandom_range(0, 19) == 0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else if (rx_bursts && $urandom_range(0, 9) == 0) begin
      rx_hold = $urandom_range(0, 7);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      got_r = '{out_byte, out_valid, out_last};
      if (transcoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte=%02h valid=%0b last=%0b",
                 $time, got_r.data, got_r.valid, got_r.last);
      end else begin
        want_r = transcoded_q.pop_front();
        if (got_r.data !== want_r.data || got_r.valid !== want_r.valid ||
            got_r.last !== want_r.last) begin
          errors++;
          $display("%0t: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                   $time, want_r.data, want_r.valid, want_r.last,
                   got_r.data, got_r.valid, got_r.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    codec_mode = MODE_ENCODE;
    clear_codec_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_encode_edges();
    test_decode_edges();
    test_mode_write_clears();
    test_random(1470, 1'b1);
    test_random(150, 1'b0);
    drain_outputs();
    repeat (16) @(posedge clk);
    if (transcoded_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, transcoded_q.size());
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/b64u_pkg.sv
design/b64u_front.sv
design/b64u_fifo.sv
design/b64u_back.sv
design/base64url_stream_codec.sv
design/b64u_checker.sv
tb/base64url_stream_codec_tb.sv
